// File: hw/rtl/slu_pkg.sv
// Shared types and constants for the sequential list engine.
// Depends on nothing; used by slu_cell, the top level and the testbench.
package slu_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned CNT_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Per-cell control, driven by the top level sequencer.
  typedef struct packed {
    logic cmp_en;    // capture compare result
    logic wr_en;     // load the write value
    logic shift_en;  // take the upper neighbor's value
  } cell_ctrl_t;

endpackage

// File: hw/rtl/slu_cell.sv
// One list cell: a stored value and a registered match flag.
// Depends on slu_pkg (cell_ctrl_t, VAL_W).
module slu_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slu_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          live_i,
  input  logic [slu_pkg::VAL_W-1:0]     cmp_key_i,
  input  logic [slu_pkg::VAL_W-1:0]     wr_data_i,
  input  logic [slu_pkg::VAL_W-1:0]     nbr_data_i,
  output logic [slu_pkg::VAL_W-1:0]     data_o,
  output logic                          match_o
);

  logic [slu_pkg::VAL_W-1:0] data_q, data_d;
  logic                      match_q, match_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.wr_en) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift_en) begin
      data_d = nbr_data_i;
    end
  end

  // Compare only live entries; dead cells never report a hit.
  assign match_d = ctrl_i.cmp_en ? (live_i && (data_q == cmp_key_i)) : match_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// File: hw/rtl/slu_ffs.sv
// Lowest-hit finder over the row of cell match flags: index and upper mask.
// Depends on nothing but its parameter.
module slu_ffs #(
  parameter int unsigned N = 128
) (
  input  logic [N-1:0]                          match_i,
  output logic                                  any_o,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0]  idx_o,
  output logic [N-1:0]                          ge_mask_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]  lowbit;
  logic [IW-1:0] idx;

  // Isolate the lowest set bit, then mark it and everything above.
  assign lowbit    = match_i & (~match_i + N'(1));
  assign ge_mask_o = ~(lowbit - N'(1));
  assign any_o     = |match_i;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      idx = idx | ({IW{lowbit[i]}} & IW'(i));
    end
  end

  assign idx_o = idx;

endmodule

// File: hw/rtl/sequential_list_engine_unit.sv
// Top level of the sequential list engine: a row of list cells plus sequencer.
// Depends on slu_pkg, slu_cell and slu_ffs.
//
// Usage:
//   Present command_i (0 insert, 1 remove, 2 search) and value_i with start_i
//   high. A command transfers at a rising edge where start_i is high and
//   busy_o is low. Every command yields exactly one result: done_o pulses for
//   one cycle with status_o, position_o and count_o valid in that cycle.
//   The receiver cannot stall; the result is gone after that cycle.
// Timing:
//   At the transfer edge every cell compares its entry with value_i in
//   parallel and registers a live-qualified match flag.
//   Execute state: the lowest hit is found by a one-hot isolate over the match row;
//   inserts write the cell at the current count, removes shift every cell at
//   or above the hit down by one from its upper neighbor. The result is
//   registered at the end of the execute state.
//   When done_o is high, busy_o is already low, so a new command may transfer
//   then; busy_o stays high while a command executes, so commands never overlap.
// Reset:
//   rst_ni empties the list (count zero) and returns to idle. Cell contents
//   are not cleared; only entries below the count can ever report a match.
module sequential_list_engine_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [slu_pkg::CMD_W-1:0]      command_i,
  input  logic signed [slu_pkg::VAL_W-1:0] value_i,
  output logic                           done_o,
  output logic [slu_pkg::STAT_W-1:0]     status_o,
  output logic [slu_pkg::POS_W-1:0]      position_o,
  output logic [slu_pkg::CNT_W-1:0]      count_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = slu_pkg::POS_W;
  localparam int unsigned CNT_W = slu_pkg::CNT_W;
  localparam int unsigned VAL_W = slu_pkg::VAL_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  // Sequencer and list state.
  logic                    state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [slu_pkg::CMD_W-1:0] cmd_q;
  logic [VAL_W-1:0]        key_q;
  logic                    accept;

  // Result registers.
  logic                      done_q, done_d;
  logic [slu_pkg::STAT_W-1:0] status_q, status_d;
  logic [POS_W-1:0]          pos_q, pos_d;

  // Cell row.
  slu_pkg::cell_ctrl_t     ctrl   [CAPACITY];
  logic [CAPACITY-1:0]     live;
  logic [CAPACITY-1:0]     ins_sel;
  logic [CAPACITY-1:0]     wr_en;
  logic [CAPACITY-1:0]     shift_en;
  logic [CAPACITY-1:0]     match;
  logic [VAL_W-1:0]        cell_data [CAPACITY];

  // Lowest hit.
  logic                    hit_any;
  logic [IDX_W-1:0]        hit_idx;
  logic [CAPACITY-1:0]     ge_mask;

  logic                    full;
  logic [IDX_W-1:0]        res_idx;
  logic [IDX_W+POS_W-1:0]  pos_ext;
  logic [CW+CNT_W-1:0]     cnt_ext;

  assign busy_o = (state_q == S_RUN);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CW'(CAPACITY));

  // Per-cell decode of the count: live range and the append slot.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]    = (CW'(i) < count_q);
      ins_sel[i] = (CW'(i) == count_q);
    end
  end

  slu_ffs #(
    .N (CAPACITY)
  ) u_ffs (
    .match_i   (match),
    .any_o     (hit_any),
    .idx_o     (hit_idx),
    .ge_mask_o (ge_mask)
  );

  // Execute step: decide writes, shifts, count and the result.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    wr_en    = '0;
    shift_en = '0;
    done_d   = 1'b0;
    status_d = status_q;
    res_idx  = '0;
    pos_d    = pos_q;
    pos_ext  = '0;

    if (accept) begin
      state_d = S_RUN;
    end

    if (state_q == S_RUN) begin
      state_d  = S_IDLE;
      done_d   = 1'b1;
      status_d = slu_pkg::ST_NOT_FOUND;
      case (cmd_q)
        slu_pkg::CMD_INSERT: begin
          if (full) begin
            status_d = slu_pkg::ST_FULL;
          end else begin
            wr_en    = ins_sel;
            count_d  = count_q + CW'(1);
            res_idx  = count_q[IDX_W-1:0];
            status_d = slu_pkg::ST_OK;
          end
        end
        slu_pkg::CMD_REMOVE: begin
          if (hit_any) begin
            // Close the gap: every cell from the hit upward takes its neighbor.
            shift_en = ge_mask;
            count_d  = count_q - CW'(1);
            res_idx  = hit_idx;
            status_d = slu_pkg::ST_OK;
          end
        end
        slu_pkg::CMD_SEARCH: begin
          if (hit_any) begin
            res_idx  = hit_idx;
            status_d = slu_pkg::ST_OK;
          end
        end
        default: begin
          // Unused code: report not found, change nothing.
        end
      endcase
      pos_ext = {{POS_W{1'b0}}, res_idx};
      pos_d   = pos_ext[POS_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].cmp_en   = accept;
      ctrl[i].wr_en    = wr_en[i];
      ctrl[i].shift_en = shift_en[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (g == CAPACITY - 1) begin : g_top
      // Top cell has no upper neighbor; hold its own value.
      assign nbr = cell_data[g];
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end

    slu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .live_i     (live[g]),
      .cmp_key_i  (value_i),
      .wr_data_i  (key_q),
      .nbr_data_i (nbr),
      .data_o     (cell_data[g]),
      .match_o    (match[g])
    );
  end

  // Latch the command at transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= value_i;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  assign cnt_ext    = {{CNT_W{1'b0}}, count_q};
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign position_o = pos_q;
  assign count_o    = cnt_ext[CNT_W-1:0];

  // A result strobe only ever follows an execute cycle.
  a_done_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_RUN))
    else $error("result strobe without execute cycle");

  // Execute is never held; idle always follows it.
  a_run_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |=> (state_q == S_IDLE))
    else $error("execute state held");

  // Count stays within capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  // A full report comes only with a full list.
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == slu_pkg::ST_FULL)) |-> (count_q == CW'(CAPACITY)))
    else $error("full reported on non-full list");

  // At most one cell is written per execute.
  a_single_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_en))
    else $error("multiple cells written");

endmodule

// File: tb/tb_sequential_list_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequential_list_engine_unit: a shadow list predicts every
// insert, remove and search and each result is checked field by field. Depends on slu_pkg.
module tb_sequential_list_engine_unit;

  localparam int unsigned CAPACITY   = 128;
  // undefined opcode, answered as not found
  localparam logic [slu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One expected result of the list engine.
  typedef struct packed {
    slu_pkg::status_e                status;
    logic [slu_pkg::POS_W-1:0]       position;
    logic [slu_pkg::CNT_W-1:0]       count;
  } list_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start_i = 1'b0;
  logic                             busy_o;
  logic [slu_pkg::CMD_W-1:0]        command_i = '0;
  logic signed [slu_pkg::VAL_W-1:0] value_i = '0;
  logic                             done_o;
  logic [slu_pkg::STAT_W-1:0]       status_o;
  logic [slu_pkg::POS_W-1:0]        position_o;
  logic [slu_pkg::CNT_W-1:0]        count_o;

  // Shadow copy of the list contents, lowest index first.
  logic [slu_pkg::VAL_W-1:0] shadow_list_q[$];
  // Results still owed by the block, oldest first.
  list_result_t              owed_results_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned n_insert = 0, n_remove = 0, n_search = 0, n_unused = 0;
  int unsigned n_full = 0, n_miss = 0, peak_fill = 0;
  int unsigned cycle_cnt = 0;

  sequential_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // End the run with a failure once the cycle limit is reached.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
             owed_results_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // Lowest index holding the key, or -1 when the list has no such entry.
  function automatic int lowest_match(logic [slu_pkg::VAL_W-1:0] key);
    for (int i = 0; i < shadow_list_q.size(); i++) begin
      if (shadow_list_q[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow list and return the result it must produce.
  function automatic list_result_t apply_list_command(logic [slu_pkg::CMD_W-1:0] cmd,
                                                     logic [slu_pkg::VAL_W-1:0] val);
    list_result_t res;
    int hit;
    res.status   = slu_pkg::ST_NOT_FOUND;
    res.position = '0;
    hit = lowest_match(val);
    case (cmd)
      slu_pkg::CMD_INSERT: begin
        n_insert++;
        if (shadow_list_q.size() < CAPACITY) begin
          res.status   = slu_pkg::ST_OK;
          res.position = slu_pkg::POS_W'(shadow_list_q.size());
          shadow_list_q.push_back(val);
        end else begin
          res.status = slu_pkg::ST_FULL;
          n_full++;
        end
      end
      slu_pkg::CMD_REMOVE: begin
        n_remove++;
        if (hit >= 0) begin
          // Close the gap: every later entry moves down one place.
          res.status   = slu_pkg::ST_OK;
          res.position = slu_pkg::POS_W'(hit);
          shadow_list_q.delete(hit);
        end
      end
      slu_pkg::CMD_SEARCH: begin
        n_search++;
        if (hit >= 0) begin
          res.status   = slu_pkg::ST_OK;
          res.position = slu_pkg::POS_W'(hit);
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    if (res.status == slu_pkg::ST_NOT_FOUND) n_miss++;
    if (shadow_list_q.size() > peak_fill) peak_fill = shadow_list_q.size();
    res.count = slu_pkg::CNT_W'(shadow_list_q.size());
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_cnt++;
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Hold start until the command transfers, record what it must return, then
  // idle at random with junk on the command fields.
  task automatic send_command(logic [slu_pkg::CMD_W-1:0] cmd,
                              logic [slu_pkg::VAL_W-1:0] val);
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy_o);
    owed_results_q.push_back(apply_list_command(cmd, val));
    while ($urandom_range(99) < send_idle_pct) begin
      start_i   <= 1'b0;
      command_i <= slu_pkg::CMD_W'($urandom());
      value_i   <= $urandom();
      @(posedge clk_i);
    end
  endtask

  // Check every result against the oldest owed one; results cannot be stalled.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o) begin
      if (owed_results_q.size() == 0) begin
        flag_mismatch("unexpected result, status", status_o, 0);
      end else begin
        want = owed_results_q.pop_front();
        if (status_o !== want.status)     flag_mismatch("status", status_o, want.status);
        if (position_o !== want.position) flag_mismatch("position", position_o, want.position);
        if (count_o !== want.count)       flag_mismatch("count", count_o, want.count);
      end
    end
  end

  // Mostly a few repeating values, so removes and searches hit duplicates.
  function automatic logic [slu_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5, 6: return slu_pkg::VAL_W'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  // Mostly a value already in the list, if there is one, so the operation hits.
  function automatic logic [slu_pkg::VAL_W-1:0] pick_live_value();
    if (shadow_list_q.size() == 0 || $urandom_range(3) == 0) return pick_value();
    return shadow_list_q[$urandom_range(shadow_list_q.size() - 1)];
  endfunction

  // Empty list, extreme values, duplicates, misses and the unused opcode.
  task automatic test_basic_ops();
    send_command(slu_pkg::CMD_SEARCH, 32'h0000_0000);   // search an empty list
    send_command(slu_pkg::CMD_REMOVE, 32'h8000_0000);   // remove from an empty list
    send_command(slu_pkg::CMD_INSERT, 32'h8000_0000);
    send_command(slu_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_command(slu_pkg::CMD_INSERT, 32'h0000_0000);
    send_command(slu_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_command(slu_pkg::CMD_INSERT, 32'h5555_5555);
    send_command(slu_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_command(slu_pkg::CMD_INSERT, 32'h7FFF_FFFF);   // duplicate of index 1
    send_command(slu_pkg::CMD_SEARCH, 32'h7FFF_FFFF);   // must report the lower index
    send_command(slu_pkg::CMD_SEARCH, 32'hAAAA_AAAA);
    send_command(slu_pkg::CMD_SEARCH, 32'h8000_0000);
    send_command(slu_pkg::CMD_SEARCH, 32'h7FFF_FFFE);   // one bit off, no hit
    send_command(slu_pkg::CMD_REMOVE, 32'h7FFF_FFFF);   // removes the first copy only
    send_command(slu_pkg::CMD_SEARCH, 32'h7FFF_FFFF);   // second copy has moved down
    send_command(slu_pkg::CMD_REMOVE, 32'h1234_5678);   // miss, nothing changes
    send_command(CMD_UNUSED, 32'hFFFF_FFFF);            // ignored opcode
    send_command(CMD_UNUSED, 32'h0000_0000);
    send_command(slu_pkg::CMD_REMOVE, 32'h8000_0000);   // remove the head
    send_command(slu_pkg::CMD_REMOVE, 32'h7FFF_FFFF);   // remove the tail
    send_command(slu_pkg::CMD_SEARCH, 32'h5555_5555);
  endtask

  // Fill to capacity, bounce inserts off the full list, hit the top index,
  // then drain in random order.
  task automatic test_full_list();
    logic [slu_pkg::VAL_W-1:0] top_val;
    while (shadow_list_q.size() > 0) send_command(slu_pkg::CMD_REMOVE, shadow_list_q[0]);
    while (shadow_list_q.size() < CAPACITY) send_command(slu_pkg::CMD_INSERT, $urandom());
    send_command(slu_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_command(slu_pkg::CMD_INSERT, 32'h8000_0000);
    top_val = shadow_list_q[CAPACITY - 1];
    send_command(slu_pkg::CMD_SEARCH, top_val);
    send_command(slu_pkg::CMD_SEARCH, shadow_list_q[0]);
    send_command(slu_pkg::CMD_REMOVE, shadow_list_q[0]);     // shift the whole row
    send_command(slu_pkg::CMD_SEARCH, top_val);
    send_command(slu_pkg::CMD_INSERT, 32'hFFFF_FFFF);        // refill the top cell
    send_command(slu_pkg::CMD_INSERT, 32'h0000_0001);        // list is full again; reported as full
    send_command(slu_pkg::CMD_REMOVE, shadow_list_q[CAPACITY - 1]);
    while (shadow_list_q.size() > 0)
      send_command(slu_pkg::CMD_REMOVE,
                   shadow_list_q[$urandom_range(shadow_list_q.size() - 1)]);
    send_command(slu_pkg::CMD_SEARCH, top_val);
  endtask

  // Random mix; the insert share changes every 50 commands so the fill level
  // wanders from empty toward full and back.
  task automatic test_random_mix(int unsigned n_items, int unsigned idle_pct);
    int unsigned insert_pct;
    int unsigned roll;
    insert_pct = 50;
    send_idle_pct = idle_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 50 == 0) insert_pct = 20 + 25 * $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < insert_pct)          send_command(slu_pkg::CMD_INSERT, pick_value());
      else if (roll < insert_pct + 2) send_command(CMD_UNUSED, $urandom());
      else if (roll[0])               send_command(slu_pkg::CMD_REMOVE, pick_live_value());
      else                            send_command(slu_pkg::CMD_SEARCH, pick_live_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 0;
    test_basic_ops();
    send_idle_pct = 6;
    test_full_list();
    test_random_mix(360, 6);
    test_random_mix(330, 86);
    test_random_mix(360, 0);

    // Drop start and let the last results drain.
    start_i <= 1'b0;
    while (owed_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d inserts, %0d removes, %0d searches, %0d unused opcodes",
             n_insert, n_remove, n_search, n_unused);
    $display("saw %0d full-list and %0d not-found answers, peak fill %0d of %0d, %0d mismatches",
             n_full, n_miss, peak_fill, CAPACITY, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/slu_pkg.sv
hw/rtl/slu_cell.sv
hw/rtl/slu_ffs.sv
hw/rtl/sequential_list_engine_unit.sv
tb/tb_sequential_list_engine_unit.sv
